/* hw/rtl/rule_conflict_resolver_defines.svh */
// Assertion macros shared by the rule conflict resolver RTL.
`ifndef RULE_CONFLICT_RESOLVER_DEFINES_SVH
`define RULE_CONFLICT_RESOLVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rcr_pkg.sv */
// Types, constants and the compare function of the rule conflict resolver.
package rcr_pkg;

  localparam int MAX_RULES = 256;
  localparam int RIDX_W    = $clog2(MAX_RULES);
  localparam int TS_W      = 32;
  localparam int PADDR_W   = 3;

  localparam logic [15:0] CYCLE_LIMIT_RESET = 16'd1000;

  localparam logic REG_STRATEGY    = 1'b0;
  localparam logic REG_CYCLE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    STRAT_ORDER    = 2'd0,
    STRAT_SPECIFIC = 2'd1,
    STRAT_RECENCY  = 2'd2,
    STRAT_SALIENCE = 2'd3
  } strategy_t;

  typedef enum logic [1:0] {
    STATUS_FIRED     = 2'd0,
    STATUS_QUIESCENT = 2'd1,
    STATUS_LIMIT     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]         rule_index;
    logic               matched;
    logic [TS_W-1:0]    fact_ts;
    logic [7:0]         cond_count;
    logic signed [15:0] salience;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [7:0]      winner_index;
    logic [TS_W-1:0] winner_ts;
    logic [15:0]     fired_total;
  } out_word_t;

  // Candidate or running best of a round.
  typedef struct packed {
    logic [7:0]         idx;
    logic [TS_W-1:0]    ts;
    logic [7:0]         conds;
    logic signed [15:0] sal;
  } rule_rec_t;

  // True when the candidate displaces the current best.
  function automatic logic cand_beats(strategy_t strat, rule_rec_t cand, rule_rec_t best);
    logic lower;
    logic res;
    lower = cand.idx < best.idx;
    unique case (strat)
      STRAT_ORDER: begin
        res = lower;
      end
      STRAT_SPECIFIC: begin
        res = (cand.conds != best.conds) ? (cand.conds > best.conds) : lower;
      end
      STRAT_RECENCY: begin
        if (cand.ts != best.ts) begin
          res = cand.ts > best.ts;
        end else if (cand.conds != best.conds) begin
          res = cand.conds > best.conds;
        end else begin
          res = lower;
        end
      end
      STRAT_SALIENCE: begin
        res = (cand.sal != best.sal) ? (cand.sal > best.sal) : lower;
      end
      default: begin
        res = lower;
      end
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/rule_conflict_resolver.sv */
// Rule conflict resolver: refraction table, running best and round close-out.
// A round's last word passes the evaluation stage; its result word is then registered in the output register.
// Throughput: one word per cycle; the input stalls only while a closing word waits on a full,
// stalled output register, since the table read and the best compare share one stage.
// Reset (synchronous, active low) clears the fired flags, counters, valid flags and configuration registers;
// the timestamp memory needs no clearing pass because a flag guards every entry.
`include "rule_conflict_resolver_defines.svh"

module rule_conflict_resolver (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rcr_pkg::in_word_t      in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rcr_pkg::out_word_t     out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [rcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import rcr_pkg::*;

  localparam int RANGE_W = RIDX_W + 1;

  // Configuration registers.
  strategy_t   strategy_r;
  logic [15:0] cycle_limit_r;

  // Timestamp recorded when each rule last fired; registered into rd_data_r as the word is taken.
  logic [TS_W-1:0] ts_mem [MAX_RULES];
  logic [TS_W-1:0] rd_data_r;

  // Fired flags live in flops so that reset clears them at once.
  logic [MAX_RULES-1:0] has_fired_r;

  // Forwarding of a table write that lands in the same cycle as the read.
  logic            fwd_hit_r;
  logic [TS_W-1:0] fwd_data_r;

  // Evaluation stage.
  logic     s1_v_r;
  in_word_t s1_r;

  // Running best of the round.
  logic      best_valid_r;
  rule_rec_t best_r;

  logic [15:0] round_count_r;
  logic [15:0] fire_count_r;

  logic      out_v_r;
  out_word_t out_r;

  logic              adv;
  logic              in_acc;
  logic              s1_done;
  logic              cfg_wr;
  logic [RIDX_W-1:0] in_addr;
  logic [RIDX_W-1:0] s1_addr;
  logic              in_range;
  logic [TS_W-1:0]   prev_ts;
  logic              eligible;
  rule_rec_t         cand;
  logic              cand_wins;
  logic              final_valid;
  rule_rec_t         final_best;
  logic              limit_hit;
  logic              mem_we;
  logic [RIDX_W-1:0] mem_waddr;
  logic [TS_W-1:0]   mem_wdata;
  out_word_t         res;

  // The pipeline holds only when a closing word needs the output register and it is blocked.
  assign adv      = !(s1_v_r && s1_r.last && out_v_r && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;
  assign s1_done  = s1_v_r && adv;

  assign in_addr  = RIDX_W'(in_data.rule_index);
  assign s1_addr  = RIDX_W'(s1_r.rule_index);
  assign in_range = RANGE_W'(s1_r.rule_index) < RANGE_W'(MAX_RULES);

  // A rule is refracted when it has fired and its match is not newer than that firing.
  assign prev_ts  = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign eligible = s1_r.matched && in_range &&
                    (!has_fired_r[s1_addr] || (s1_r.fact_ts > prev_ts));

  assign cand.idx   = s1_r.rule_index;
  assign cand.ts    = s1_r.fact_ts;
  assign cand.conds = s1_r.cond_count;
  assign cand.sal   = s1_r.salience;

  assign cand_wins   = eligible && (!best_valid_r || cand_beats(strategy_r, cand, best_r));
  assign final_valid = best_valid_r || cand_wins;
  assign final_best  = cand_wins ? cand : best_r;

  // A round that closes at or past the limit fires nothing and is not counted.
  assign limit_hit = round_count_r >= cycle_limit_r;
  assign mem_we    = s1_done && s1_r.last && !limit_hit && final_valid;
  assign mem_waddr = RIDX_W'(final_best.idx);
  assign mem_wdata = final_best.ts;

  always_comb begin
    res = '0;
    if (limit_hit) begin
      res.status = STATUS_LIMIT;
    end else if (final_valid) begin
      res.status       = STATUS_FIRED;
      res.winner_index = final_best.idx;
      res.winner_ts    = final_best.ts;
    end else begin
      res.status = STATUS_QUIESCENT;
    end
    res.fired_total = mem_we ? (fire_count_r + 16'd1) : fire_count_r;
  end

  // Table memory: one read port, one write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ts_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_data_r  <= ts_mem[in_addr];
      fwd_hit_r  <= mem_we && (mem_waddr == in_addr);
      fwd_data_r <= mem_wdata;
    end
  end

  // Evaluation stage payload and running best payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (s1_done) begin
      best_r <= s1_r.last ? '0 : final_best;
    end
    if (s1_done && s1_r.last) begin
      out_r <= res;
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      best_valid_r  <= 1'b0;
      has_fired_r   <= '0;
      round_count_r <= '0;
      fire_count_r  <= '0;
      out_v_r       <= 1'b0;
      strategy_r    <= STRAT_ORDER;
      cycle_limit_r <= CYCLE_LIMIT_RESET;
    end else begin
      if (adv) begin
        s1_v_r <= in_acc;
      end
      if (s1_done) begin
        best_valid_r <= s1_r.last ? 1'b0 : final_valid;
      end
      if (s1_done && s1_r.last && !limit_hit) begin
        round_count_r <= round_count_r + 16'd1;
      end
      if (mem_we) begin
        has_fired_r[mem_waddr] <= 1'b1;
        fire_count_r           <= fire_count_r + 16'd1;
      end
      if (s1_done && s1_r.last) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_STRATEGY: begin
            strategy_r <= strategy_t'(pwdata[1:0]);
          end
          REG_CYCLE_LIMIT: begin
            cycle_limit_r <= pwdata[15:0];
          end
          default: begin
            strategy_r <= strategy_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STRATEGY:    prdata = {30'd0, strategy_r};
      REG_CYCLE_LIMIT: prdata = {16'd0, cycle_limit_r};
      default:         prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Input is held back only by a blocked result.
  `RCR_ASSERT_NOW(a_stall_cause, in_stall, out_v_r && out_stall && s1_v_r && s1_r.last, "input stalled without a blocked result")
  // Every table write is reported as a firing in the next cycle.
  `RCR_ASSERT_NXT(a_write_fires, mem_we, out_v_r && (out_r.status == STATUS_FIRED), "table write without a fired result")
  // A closed round leaves no running best behind.
  `RCR_ASSERT_NXT(a_best_cleared, s1_done && s1_r.last, !best_valid_r, "running best survived round close")
  // Only counted rounds fire.
  `RCR_ASSERT_NOW(a_fire_le_round, 1'b1, fire_count_r <= round_count_r, "fired count exceeds round count")

endmodule

/* tb/rule_conflict_resolver_checker.sv */
// Checker that predicts the rule conflict resolver's round results and compares them.
module rule_conflict_resolver_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  rcr_pkg::in_word_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  rcr_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcr_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_STRATEGY = {REG_STRATEGY, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_LIMIT    = {REG_CYCLE_LIMIT, 2'b00};

  // Refraction table, indexed by rule.
  logic               fired_flag [MAX_RULES];
  logic [TS_W-1:0]    refr_stamp [MAX_RULES];

  // Leading candidate of the open round.
  logic               lead_valid;
  logic [7:0]         lead_idx;
  logic [TS_W-1:0]    lead_ts;
  logic [7:0]         lead_conds;
  logic signed [15:0] lead_sal;

  strategy_t          strat;
  logic [15:0]        round_limit;
  logic [15:0]        rounds_run;
  logic [15:0]        fires_done;
  out_word_t          round_outcomes [$];

  // True when the word takes the lead from the current leader.
  function automatic logic outranks(in_word_t w);
    logic earlier;
    logic wins;
    earlier = w.rule_index < lead_idx;
    case (strat)
      STRAT_ORDER: begin
        wins = earlier;
      end
      STRAT_SPECIFIC: begin
        if (w.cond_count != lead_conds) wins = w.cond_count > lead_conds;
        else wins = earlier;
      end
      STRAT_RECENCY: begin
        if (w.fact_ts != lead_ts) wins = w.fact_ts > lead_ts;
        else if (w.cond_count != lead_conds) wins = w.cond_count > lead_conds;
        else wins = earlier;
      end
      default: begin
        if ($signed(w.salience) != lead_sal) wins = $signed(w.salience) > lead_sal;
        else wins = earlier;
      end
    endcase
    return wins;
  endfunction

  task automatic clear_lead();
    lead_valid = 1'b0;
    lead_idx   = '0;
    lead_ts    = '0;
    lead_conds = '0;
    lead_sal   = '0;
  endtask

  // Folds one accepted word into the round; a closing word yields the round's outcome.
  task automatic resolve_word(in_word_t w);
    out_word_t res;
    if (w.matched && (!fired_flag[w.rule_index] || w.fact_ts > refr_stamp[w.rule_index])) begin
      if (!lead_valid || outranks(w)) begin
        lead_valid = 1'b1;
        lead_idx   = w.rule_index;
        lead_ts    = w.fact_ts;
        lead_conds = w.cond_count;
        lead_sal   = $signed(w.salience);
      end
    end
    if (w.last) begin
      res = '0;
      if (rounds_run >= round_limit) begin
        res.status = STATUS_LIMIT;
      end else begin
        rounds_run = rounds_run + 16'd1;
        if (lead_valid) begin
          fired_flag[lead_idx] = 1'b1;
          refr_stamp[lead_idx] = lead_ts;
          fires_done           = fires_done + 16'd1;
          res.status           = STATUS_FIRED;
          res.winner_index     = lead_idx;
          res.winner_ts        = lead_ts;
        end else begin
          res.status = STATUS_QUIESCENT;
        end
      end
      res.fired_total = fires_done;
      round_outcomes.push_back(res);
      clear_lead();
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_RULES; i++) fired_flag[i] = 1'b0;
      clear_lead();
      strat       = STRAT_ORDER;
      round_limit = CYCLE_LIMIT_RESET;
      rounds_run  = '0;
      fires_done  = '0;
      fail_count  = 0;
      round_outcomes.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_STRATEGY) strat = strategy_t'(pwdata[1:0]);
          else if (paddr == ADDR_LIMIT) round_limit = pwdata[15:0];
        end else if (paddr == ADDR_STRATEGY) begin
          check_field("strategy readback", {30'd0, strat}, prdata);
        end else if (paddr == ADDR_LIMIT) begin
          check_field("cycle_limit readback", {16'd0, round_limit}, prdata);
        end
      end
      if (in_valid && !in_stall) resolve_word(in_data);
      if (out_valid && !out_stall) begin
        if (round_outcomes.size() == 0) begin
          $error("result word with no round outcome waiting");
          fail_count++;
        end else begin
          want = round_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("winner_index", 32'(want.winner_index), 32'(out_data.winner_index));
          check_field("winner_ts", want.winner_ts, out_data.winner_ts);
          check_field("fired_total", 32'(want.fired_total), 32'(out_data.fired_total));
        end
      end
    end
    pending = round_outcomes.size();
  end

endmodule

/* tb/rule_conflict_resolver_test.sv */
// Top of the rule conflict resolver testbench: clock, reset, stimulus and verdict.
module rule_conflict_resolver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rcr_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_STRATEGY = {REG_STRATEGY, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_LIMIT    = {REG_CYCLE_LIMIT, 2'b00};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_word_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int                 fail_count;
  int                 pending;

  // Pacing knobs, changed from phase to phase. A percentage of zero turns that
  // kind of idling off, which gives the stretches of back-to-back traffic.
  int                 stall_pct = 0;
  int                 gap_pct = 0;
  int                 burst_left = 0;

  // Stimulus bookkeeping. The top mirrors the round counter only so that it can
  // place a cycle limit a few rounds ahead of the current count.
  int                 words_sent = 0;
  int                 rounds_done = 0;
  int                 limit_now = int'(CYCLE_LIMIT_RESET);
  bit                 round_open = 1'b0;
  logic [TS_W-1:0]    fact_clock;

  rule_conflict_resolver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  rule_conflict_resolver_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // The whole run ends well inside this timeout even when every gap and
  // every stall burst comes out at its longest, so this only catches a hang.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side back-pressure. Short random stalls at the phase's rate, plus an
  // occasional long burst so that the output register fills and the stall
  // reaches back to the input side.
  always @(negedge clk) begin
    if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(999, 0) < 15) begin
      burst_left <= $urandom_range(40, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  function automatic in_word_t rule_word(int idx, bit m, logic [TS_W-1:0] ts, int conds,
                                         int sal, bit fin);
    in_word_t w;
    w.rule_index = idx[7:0];
    w.matched    = m;
    w.fact_ts    = ts;
    w.cond_count = conds[7:0];
    w.salience   = sal[15:0];
    w.last       = fin;
    return w;
  endfunction

  // Every sending task starts and ends at a falling edge. The optional gap
  // lowers valid first; either way valid gets one assignment per falling edge.
  task automatic send_word(in_word_t w);
    int n;
    n = 0;
    if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
      n = ($urandom_range(19, 0) == 0) ? $urandom_range(30, 6) : $urandom_range(2, 1);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
    round_open = !w.last;
    if (w.last && rounds_done < limit_now) rounds_done++;
  endtask

  // Stop sending and wait until the checker has seen every predicted result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Between phases: a word that closes no round may still be in the pipeline
  // when the last result shows up, so allow the block's latency on top.
  task automatic settle();
    drain_results();
    repeat (4) @(negedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(bit wr, logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write a register and read it back; the checker compares the read data.
  task automatic set_reg(logic [PADDR_W-1:0] addr, int value);
    cfg_access(1'b1, addr, value);
    cfg_access(1'b0, addr, '0);
    if (addr == ADDR_LIMIT) limit_now = value;
  endtask

  // A well-formed round: ascending rule indexes, mostly drawn from a small rule
  // base so that the same rules come back round after round. Timestamps mostly
  // sit just at or behind a slowly moving fact clock, which makes refraction hit
  // often, and small ranges for specificity and salience make ties common.
  task automatic send_round();
    int n;
    int idx;
    in_word_t w;
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    idx = ($urandom_range(3, 0) == 0) ? $urandom_range(255 - 3 * (n - 1), 0)
                                      : $urandom_range(3, 0);
    fact_clock = fact_clock + $urandom_range(3, 0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9, 0))
        0:       w.fact_ts = $urandom;
        1:       w.fact_ts = {TS_W{$urandom_range(1, 0) == 1}};
        default: w.fact_ts = fact_clock - $urandom_range(4, 0);
      endcase
      w.rule_index = idx[7:0];
      w.matched    = ($urandom_range(9, 0) < 7);
      w.cond_count = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0))
                                                 : 8'($urandom_range(5, 0));
      w.salience   = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(6, 0) - 3);
      w.last       = (i == n - 1);
      send_word(w);
      idx += $urandom_range(3, 1);
    end
  endtask

  // Noise: words with unrelated content, repeated or out-of-order indexes, and a
  // close flag that may or may not come, so rounds get cut short or run on.
  task automatic send_noise();
    in_word_t w;
    repeat ($urandom_range(6, 1)) begin
      w.rule_index = ($urandom_range(1, 0) == 0) ? 8'($urandom_range(255, 0))
                                                 : 8'($urandom_range(3, 0));
      w.matched    = 1'($urandom_range(1, 0));
      w.fact_ts    = ($urandom_range(1, 0) == 0) ? $urandom : fact_clock;
      w.cond_count = 8'($urandom_range(255, 0));
      w.salience   = 16'($urandom);
      w.last       = ($urandom_range(3, 0) == 0);
      send_word(w);
    end
  endtask

  // A phase: wait for the block to go idle, set both registers, then mix
  // well-formed rounds with noise until the word budget is spent. A phase always
  // ends on a closed round so that the next register write lands between rounds.
  task automatic run_phase(int quota, strategy_t strat, int limit, int pace, bit hold_mid);
    int start;
    bit held;
    settle();
    set_reg(ADDR_STRATEGY, strat);
    set_reg(ADDR_LIMIT, limit);
    case (pace)
      0: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct   = 20;
        stall_pct = 25;
      end
      default: begin
        gap_pct   = 50;
        stall_pct = 50;
      end
    endcase
    start = words_sent;
    held  = 1'b0;
    while (words_sent - start < quota) begin
      if ($urandom_range(3, 0) == 0) send_noise();
      else send_round();
      // Hold the sender once, mid-phase, until every result is out.
      if (hold_mid && !held && words_sent - start >= quota / 2) begin
        held = 1'b1;
        drain_results();
      end
    end
    if (round_open) send_round();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    out_stall = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    fact_clock = $urandom;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, first under the reset settings: order strategy, limit 1000.
    // An unmatched rule, then field extremes; the lowest index fires.
    send_word(rule_word(0, 0, 0, 0, 0, 0));
    send_word(rule_word(5, 1, 0, 0, -32768, 0));
    send_word(rule_word(255, 1, 32'hFFFF_FFFF, 255, 32767, 1));
    // Rule 5 is refracted at the same timestamp, so rule 255 fires now.
    send_word(rule_word(5, 1, 0, 0, 0, 0));
    send_word(rule_word(255, 1, 32'hFFFF_FFFF, 255, 32767, 1));
    // Both refracted: the round is quiescent.
    send_word(rule_word(5, 1, 0, 0, 0, 0));
    send_word(rule_word(255, 1, 32'hFFFF_FFFF, 255, 32767, 1));
    // A one-word round with nothing matched.
    send_word(rule_word(9, 0, 7, 1, 1, 1));
    // The same rule twice in a round: on a full tie the earlier word keeps it.
    send_word(rule_word(7, 1, 10, 3, 0, 0));
    send_word(rule_word(7, 1, 20, 3, 0, 0));
    send_word(rule_word(200, 1, 1, 3, 0, 1));

    // Specificity with a tie on the condition count; the lower index wins.
    settle();
    set_reg(ADDR_STRATEGY, STRAT_SPECIFIC);
    send_word(rule_word(20, 1, 100, 4, 0, 0));
    send_word(rule_word(10, 1, 100, 4, 0, 0));
    send_word(rule_word(30, 1, 100, 2, 0, 1));

    // Recency with equal timestamps, decided by specificity.
    settle();
    set_reg(ADDR_STRATEGY, STRAT_RECENCY);
    send_word(rule_word(40, 1, 500, 1, 0, 0));
    send_word(rule_word(41, 1, 500, 6, 0, 0));
    send_word(rule_word(42, 1, 499, 9, 0, 1));

    // Salience: a negative loses, equal saliences go to the lower index.
    settle();
    set_reg(ADDR_STRATEGY, STRAT_SALIENCE);
    send_word(rule_word(50, 1, 1, 1, -5, 0));
    send_word(rule_word(51, 1, 1, 1, 3, 0));
    send_word(rule_word(49, 1, 1, 1, 3, 1));

    // A zero cycle limit stops the very next round.
    settle();
    set_reg(ADDR_LIMIT, 0);
    send_word(rule_word(60, 1, 1, 1, 0, 1));

    // Random part. Each strategy gets a phase of its own with the limit at its
    // top value, the paces vary, and one phase holds the sender halfway.
    run_phase(120, STRAT_ORDER, 16'hFFFF, 0, 1'b0);
    run_phase(120, STRAT_SPECIFIC, 16'hFFFF, 1, 1'b1);
    run_phase(120, STRAT_RECENCY, 16'hFFFF, 2, 1'b0);
    run_phase(120, STRAT_SALIENCE, 16'hFFFF, 1, 1'b0);
    // The limit is reached a few rounds into the phase.
    run_phase(100, strategy_t'($urandom_range(3, 0)), rounds_done + 5, 2, 1'b0);
    // A limit below the rounds already run blocks every round.
    run_phase(40, strategy_t'($urandom_range(3, 0)), 1, 1, 1'b0);
    repeat (4) begin
      run_phase(120, strategy_t'($urandom_range(3, 0)),
                $urandom_range(65535, rounds_done + 40), $urandom_range(2, 0), 1'b0);
    end

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
